// ----- hdl/bol_pkg.sv -----
// ----------------------------------------------------------------------------
// bol_pkg: shared types and constants for the bounded ordered list
// Capacity, widths, command codes and the structs that travel between the
// list top level and its storage cells.
// ----------------------------------------------------------------------------
package bol_pkg;

  // number of storage cells in the chain
  localparam int unsigned CAPACITY = 16;

  // field widths fixed by the interface
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned POS_W  = 5;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned LEN_W  = 5;

  // count holds 0..CAPACITY, a cell index holds 0..CAPACITY-1
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  // common width for position / count / index compares
  localparam int unsigned KEY_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  // value returned when there is nothing to read
  localparam logic signed [DATA_W-1:0] NONE_DATA = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_REMOVE = 3'd2,
    CMD_READ   = 3'd3,
    CMD_SORTED = 3'd4
  } cmd_e;

  // one command item
  typedef struct packed {
    logic [CMD_W-1:0]         command;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } cmd_t;

  // one result item
  typedef struct packed {
    logic signed [DATA_W-1:0] read_data;
    logic                     ok;
    logic [LEN_W-1:0]         length;
  } res_t;

  // broadcast control from the top level to every cell
  typedef struct packed {
    logic                     ins;       // insert at kpos (or sorted point)
    logic                     rem;       // remove at kpos
    logic                     sorted;    // insert point comes from compares
    logic                     any_found; // some held item is not smaller
    logic [KEY_W-1:0]         kpos;      // target position
    logic [KEY_W-1:0]         cnt;       // current number of items
    logic signed [DATA_W-1:0] item;      // value to place / compare
  } cell_ctl_t;

endpackage

// ----- hdl/bol_cell.sv -----
// ----------------------------------------------------------------------------
// bol_cell: one storage cell of the list chain
// Holds one entry, compares it against the incoming item and takes the
// entry of its left or right neighbor when the list opens or closes a gap.
// ----------------------------------------------------------------------------
module bol_cell (
  input  logic                              clk_i,
  input  logic [bol_pkg::IDX_W-1:0]         idx_i,      // fixed place in chain
  input  bol_pkg::cell_ctl_t                ctl_i,
  input  logic                              found_i,    // a cell to the left matched
  input  logic signed [bol_pkg::DATA_W-1:0] prev_i,     // left neighbor entry
  input  logic signed [bol_pkg::DATA_W-1:0] next_i,     // right neighbor entry
  output logic                              found_o,
  output logic signed [bol_pkg::DATA_W-1:0] entry_o
);

  logic signed [bol_pkg::DATA_W-1:0] entry_q, entry_d;
  logic [bol_pkg::KEY_W-1:0]         idx;
  logic                              held;
  logic                              ge;
  logic                              at_pos;
  logic                              after;

  assign idx  = bol_pkg::KEY_W'(idx_i);
  assign held = idx < ctl_i.cnt;

  // held entry is not smaller than the item: candidate insert point
  assign ge      = held && (entry_q >= ctl_i.item);
  assign found_o = found_i | ge;

  // where this cell sits relative to the insert point
  always_comb begin
    if (ctl_i.sorted) begin
      at_pos = (ge && !found_i) || (!ctl_i.any_found && idx == ctl_i.cnt);
      after  = found_i || (!ctl_i.any_found && idx > ctl_i.cnt);
    end else begin
      at_pos = idx == ctl_i.kpos;
      after  = idx > ctl_i.kpos;
    end
  end

  // next entry: load, shift right, shift left or hold
  always_comb begin
    entry_d = entry_q;
    if (ctl_i.ins) begin
      if (at_pos) begin
        entry_d = ctl_i.item;
      end else if (after) begin
        entry_d = prev_i;
      end
    end else if (ctl_i.rem) begin
      if (idx >= ctl_i.kpos) begin
        entry_d = next_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ----- hdl/bounded_ordered_list.sv -----
// ----------------------------------------------------------------------------
// bounded_ordered_list: bounded positional list of signed 32-bit items
// A chain of storage cells that appends, inserts, removes, reads and does
// sorted inserts, one command item at a time.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive item_i and raise start; the item is taken at a
//   rising edge where start is high and busy is low. busy stays low, so a
//   new command may be issued every cycle.
//   Result channel: one result item per command, shown on result_o with
//   done_o high for exactly one cycle, the cycle after the command is
//   taken. The receiver cannot stall; it must take the result then.
//   Throughput is 1 command per cycle: every cell
//   compares its entry and shifts toward its neighbor in the same cycle,
//   and the sorted insert point is found by a found-flag ripple through
//   the chain.
//   A read returns -1 on a bad index; ok is low on any refused command;
//   length is the item count after the command.
//   Reset clears the item count and the result strobe; entries are
//   undefined until written and are never read before that.
// ----------------------------------------------------------------------------
module bounded_ordered_list (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  bol_pkg::cmd_t   item_i,
  output logic            done_o,
  output bol_pkg::res_t   result_o
);

  localparam int unsigned N = bol_pkg::CAPACITY;

  logic [bol_pkg::CNT_W-1:0]          count_q, count_d;
  logic                               done_q;
  bol_pkg::res_t                      res_q, res_d;
  bol_pkg::cell_ctl_t                 ctl;
  logic                               accept;
  logic [bol_pkg::KEY_W-1:0]          pos;
  logic [bol_pkg::KEY_W-1:0]          cnt;
  logic                               room;
  logic                               pos_held;
  logic signed [bol_pkg::DATA_W-1:0]  entry [N];
  logic                               found [N+1];

  // engine never stalls: always ready
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign pos      = bol_pkg::KEY_W'(item_i.position);
  assign cnt      = bol_pkg::KEY_W'(count_q);
  assign room     = cnt < bol_pkg::KEY_W'(N);
  assign pos_held = pos < cnt;

  // decode command into cell control and result
  always_comb begin
    ctl           = '0;
    ctl.cnt       = cnt;
    ctl.item      = item_i.value;
    ctl.any_found = found[N];
    ctl.kpos      = pos;
    count_d       = count_q;
    res_d.read_data = bol_pkg::NONE_DATA;
    res_d.ok        = 1'b0;
    case (bol_pkg::cmd_e'(item_i.command))
      bol_pkg::CMD_APPEND: begin
        ctl.kpos = cnt;
        if (room) begin
          ctl.ins  = accept;
          res_d.ok = 1'b1;
        end
      end
      bol_pkg::CMD_INSERT: begin
        if (room && pos <= cnt) begin
          ctl.ins  = accept;
          res_d.ok = 1'b1;
        end
      end
      bol_pkg::CMD_REMOVE: begin
        if (pos_held) begin
          ctl.rem  = accept;
          res_d.ok = 1'b1;
        end
      end
      bol_pkg::CMD_READ: begin
        if (pos_held) begin
          res_d.read_data = entry[pos[bol_pkg::IDX_W-1:0]];
          res_d.ok        = 1'b1;
        end
      end
      bol_pkg::CMD_SORTED: begin
        ctl.sorted = 1'b1;
        if (room) begin
          ctl.ins  = accept;
          res_d.ok = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (ctl.ins) begin
      count_d = count_q + 1'b1;
    end else if (ctl.rem) begin
      count_d = count_q - 1'b1;
    end
    res_d.length = bol_pkg::LEN_W'(count_d);
  end

  // chain of storage cells
  assign found[0] = 1'b0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic signed [bol_pkg::DATA_W-1:0] prev_e;
    logic signed [bol_pkg::DATA_W-1:0] next_e;

    if (i == 0) begin : g_first
      assign prev_e = item_i.value;
    end else begin : g_mid
      assign prev_e = entry[i-1];
    end
    if (i == N - 1) begin : g_last
      assign next_e = entry[i];
    end else begin : g_body
      assign next_e = entry[i+1];
    end

    bol_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (bol_pkg::IDX_W'(i)),
      .ctl_i   (ctl),
      .found_i (found[i]),
      .prev_i  (prev_e),
      .next_i  (next_e),
      .found_o (found[i+1]),
      .entry_o (entry[i])
    );
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  // count never goes past the number of cells
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= bol_pkg::CNT_W'(N))
    else $error("item count exceeds capacity");

  // every accepted command gives a result in the next cycle
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o)
    else $error("missing result strobe");

  // a refused command leaves the count unchanged
  a_refused_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !res_d.ok |=> count_q == $past(count_q))
    else $error("refused command changed the count");

  // a result with a read value other than -1 comes only from a good read
  a_read_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.read_data != bol_pkg::NONE_DATA |-> result_o.ok)
    else $error("read data without success");

endmodule
